>>> hdl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition implies a consequence in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hdl/deq_pkg.sv
package deq_pkg;

    // operation codes carried in the kind field
    typedef enum logic [2:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_PEEK_FRONT = 3'd4,
        KIND_PEEK_BACK  = 3'd5
    } kind_e_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    // request payload
    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] data_in;
    } req_item_t;

    // response payload
    typedef struct packed {
        logic signed [31:0] data_out;
        logic [1:0]         status;
        logic [4:0]         count;
    } rsp_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_busy;
    } ctrl_stat_t;

endpackage

>>> hdl/deq_ctrl.sv
module deq_ctrl
    import deq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_stall  = 1'b1;
        cmd.accept = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall  = 1'b0;
                cmd.accept = req_valid;
            end
            ST_EXEC:
            begin
                cmd.commit = !stat.out_busy;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> hdl/deq_datapath.sv
module deq_datapath
    import deq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  cmd,
    output ctrl_stat_t stat,
    input  req_item_t  req,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output rsp_item_t  rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [AW-1:0]         head_reg;
    logic [AW-1:0]         head_next;
    logic [AW-1:0]         tail_reg;
    logic [AW-1:0]         tail_next;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    kind_e_t               kind_reg;
    logic [DATA_WIDTH-1:0] din_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  out_valid_reg;
    rsp_item_t             out_reg;
    rsp_item_t             out_next;

    logic [AW-1:0]          head_inc;
    logic [AW-1:0]          head_dec;
    logic [AW-1:0]          tail_inc;
    logic [AW-1:0]          tail_dec;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    logic                   wr_en;
    logic                   empty;
    logic                   full;
    logic [DATA_WIDTH-1:0]  res_w;
    status_t                res_status;
    logic [DATA_WIDTH+31:0] din_ext;
    logic [DATA_WIDTH+31:0] res_ext;
    logic [CW+4:0]          cnt_ext;

    // ring index arithmetic with wrap at the last slot
    assign head_inc = (head_reg == LAST) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? LAST : head_reg - AW'(1);
    assign tail_inc = (tail_reg == LAST) ? '0 : tail_reg + AW'(1);
    assign tail_dec = (tail_reg == '0) ? LAST : tail_reg - AW'(1);

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CW'(DEPTH));

    // read slot chosen from the incoming kind
    always_comb
    begin
        if (req.kind inside {KIND_POP_FRONT, KIND_PEEK_FRONT})
        begin
            rd_addr = head_reg;
        end
        else
        begin
            rd_addr = tail_dec;
        end
    end

    assign din_ext = {{DATA_WIDTH{1'b0}}, req.data_in};

    // capture the operation and read its slot on transfer
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg    <= kind_e_t'(req.kind);
            din_reg     <= din_ext[DATA_WIDTH-1:0];
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= din_reg;
        end
    end

    // operation decode and state update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        cnt_next   = cnt_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_reg;
        res_w      = '0;
        res_status = STATUS_OK;
        case (kind_reg)
            KIND_PUSH_FRONT:
            begin
                if (full)
                begin
                    res_status = STATUS_FULL;
                end
                else
                begin
                    wr_en     = cmd.commit;
                    wr_addr   = head_dec;
                    head_next = head_dec;
                    cnt_next  = cnt_reg + CW'(1);
                end
            end
            KIND_PUSH_BACK:
            begin
                if (full)
                begin
                    res_status = STATUS_FULL;
                end
                else
                begin
                    wr_en     = cmd.commit;
                    wr_addr   = tail_reg;
                    tail_next = tail_inc;
                    cnt_next  = cnt_reg + CW'(1);
                end
            end
            KIND_POP_FRONT:
            begin
                if (empty)
                begin
                    res_status = STATUS_EMPTY;
                end
                else
                begin
                    res_w     = rd_data_reg;
                    head_next = head_inc;
                    cnt_next  = cnt_reg - CW'(1);
                end
            end
            KIND_POP_BACK:
            begin
                if (empty)
                begin
                    res_status = STATUS_EMPTY;
                end
                else
                begin
                    res_w     = rd_data_reg;
                    tail_next = tail_dec;
                    cnt_next  = cnt_reg - CW'(1);
                end
            end
            KIND_PEEK_FRONT, KIND_PEEK_BACK:
            begin
                if (empty)
                begin
                    res_status = STATUS_EMPTY;
                end
                else
                begin
                    res_w = rd_data_reg;
                end
            end
            default:
            begin
                res_status = STATUS_OK;
            end
        endcase
    end

    // result formatting: sign extend the value, keep the low count bits
    assign res_ext = {{32{res_w[DATA_WIDTH-1]}}, res_w};
    assign cnt_ext = {5'd0, cnt_next};

    always_comb
    begin
        out_next.data_out = res_ext[31:0];
        out_next.status   = res_status;
        out_next.count    = cnt_ext[4:0];
    end

    // queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    // output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
    end

    assign stat.out_busy = out_valid_reg && rsp_stall;
    assign rsp_valid     = out_valid_reg;
    assign rsp           = out_reg;

endmodule

>>> hdl/double_ended_queue.sv
// channel | direction | payload    | handshake
// --------+-----------+------------+----------------------
// req     | in        | req_item_t | req_valid / req_stall
// rsp     | out       | rsp_item_t | rsp_valid / rsp_stall
//
// each operation runs as a transfer plus synchronous slot read, then a commit
// a new request is taken only after the previous one has committed
// commit waits while the response register holds an untaken result
// rst_n clears pointers, count and the valid flag at once; the slot memory is not cleared
// the slot memory has one write and one registered read port
`include "assert_macros.svh"

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // sequencer
    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // ring store, pointers and response register
    deq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // checks
    `ASSERT_ALWAYS(a_no_overlap, !(cmd.accept && cmd.commit), "accept and commit overlap")
    `ASSERT_NEXT(a_busy_after_xfer, req_valid && !req_stall, req_stall, "request taken while busy")
    `ASSERT_NEXT(a_commit_valid, cmd.commit, rsp_valid, "commit without response")
    `ASSERT_SAME(a_err_zero, rsp_valid && rsp.status != STATUS_OK, rsp.data_out == 32'sd0, "error with data")

endmodule
